// ===== rtl/spsp_pkg.sv =====
// Shared types and constants for the stage peer slice planner.
// Holds field widths, error codes, register indexes and the control/status structs.
// No dependencies.
`default_nettype none

package spsp_pkg;

    localparam int GS_W       = 7;   // counts, widths, group size
    localparam int IDX_W      = 6;   // peer index, split part, rank
    localparam int ERR_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int STEP_W     = 3;   // divider step counter

    localparam int MAX_PEERS_DEF = 64;

    localparam logic [ERR_W-1:0] ERR_OK         = 3'd0;
    localparam logic [ERR_W-1:0] ERR_EMPTY      = 3'd1;
    localparam logic [ERR_W-1:0] ERR_MISMATCH   = 3'd2;
    localparam logic [ERR_W-1:0] ERR_SHARD_MODE = 3'd3;
    localparam logic [ERR_W-1:0] ERR_WIDTH      = 3'd4;
    localparam logic [ERR_W-1:0] ERR_RANK       = 3'd5;
    localparam logic [ERR_W-1:0] ERR_RATIO      = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_RANK    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KV_REPLICATED = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KV_OPAQUE     = 2'd3;

    typedef enum logic [2:0] {
        PLAN_ERR,
        PLAN_SHARD,
        PLAN_REP_SRC,
        PLAN_REP_KV,
        PLAN_EQUAL,
        PLAN_FINER,
        PLAN_COARSE
    } plan_kind_t;

    typedef enum logic [1:0] {
        DIV_R_BY_GS,
        DIV_GS_BY_W,
        DIV_W_BY_GS,
        DIV_R_BY_G
    } div_sel_t;

    typedef struct packed {
        logic             capture;
        logic             div_start;
        div_sel_t         div_sel;
        logic             g_load;
        logic             plan_load;
        plan_kind_t       plan_kind;
        logic [ERR_W-1:0] err_code;
        logic             emit;
    } spsp_cmd_t;

    typedef struct packed {
        logic empty;
        logic oversize;
        logic mismatch;
        logic shard_mode_bad;
        logic sharded;
        logic width_bad;
        logic rank_bad;
        logic src_rep;
        logic kv_rep;
        logic equal;
        logic finer;
        logic div_done;
        logic rem_zero;
        logic out_free;
        logic last_item;
    } spsp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/stage_peer_slice_planner.sv =====
// Top level of the stage peer slice planner: controller plus datapath.
// Uses spsp_pkg, spsp_ctrl, spsp_dpath (which holds spsp_div).
//
// Usage:
//   Config port: cfg_wr_en/cfg_index/cfg_data write local_width (0), local_rank (1),
//   kv_replicated (2), kv_opaque (3); write only while the block is idle.
//   Input channel: in_valid/in_stall carry one request (group_size, shard_degree,
//   shard_replicated). in_stall is high from acceptance until the request's last
//   result has been loaded into the output register.
//   Output channel: out_valid/out_stall carry one slice per item; last marks the
//   final slice, error requests give one item with error_code set and last high.
//   Error, sharded and equal-width plans are loaded straight from the checks;
//   replicated or finer-source plans wait for one 7-step divide, coarser-source
//   plans for two divides. Results then follow one per cycle while the output
//   register is free. A 64-peer sharded group or a 64-slice finer source gives
//   the most slices; the serial divider and the output register set the pace.
//   out_stall holds the output register; the planner waits until it drains.
//   Reset: configuration returns to width 1, rank 0, flags clear; nothing pending.
`default_nettype none

module stage_peer_slice_planner #(
    parameter int MAX_PEERS = spsp_pkg::MAX_PEERS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [spsp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [spsp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [spsp_pkg::GS_W-1:0]       group_size,
    input  wire logic [spsp_pkg::GS_W-1:0]       shard_degree,
    input  wire logic                            shard_replicated,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [spsp_pkg::IDX_W-1:0]           peer_index,
    output logic [spsp_pkg::GS_W-1:0]            peer_split_count,
    output logic [spsp_pkg::IDX_W-1:0]           peer_split_part,
    output logic [spsp_pkg::GS_W-1:0]            local_split_count,
    output logic [spsp_pkg::IDX_W-1:0]           local_split_part,
    output logic                                 page_round_robin,
    output logic [spsp_pkg::ERR_W-1:0]           error_code,
    output logic                                 last
);
    import spsp_pkg::*;

    spsp_cmd_t  cmd;
    spsp_stat_t stat;

    spsp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    spsp_dpath #(
        .MAX_PEERS (MAX_PEERS)
    ) u_dpath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .group_size        (group_size),
        .shard_degree      (shard_degree),
        .shard_replicated  (shard_replicated),
        .out_stall         (out_stall),
        .cmd               (cmd),
        .stat              (stat),
        .out_valid         (out_valid),
        .peer_index        (peer_index),
        .peer_split_count  (peer_split_count),
        .peer_split_part   (peer_split_part),
        .local_split_count (local_split_count),
        .local_split_part  (local_split_part),
        .page_round_robin  (page_round_robin),
        .error_code        (error_code),
        .last              (last)
    );

endmodule

`default_nettype wire

// ===== rtl/spsp_div.sv =====
// Restoring radix-2 divider for 7-bit unsigned operands, one quotient bit per cycle.
// Uses spsp_pkg for widths. Divisor is never zero when started.
`default_nettype none

module spsp_div (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic [spsp_pkg::GS_W-1:0] dividend,
    input  wire logic [spsp_pkg::GS_W-1:0] divisor,
    output logic                         done,
    output logic [spsp_pkg::GS_W-1:0]    quotient,
    output logic [spsp_pkg::GS_W-1:0]    remainder
);
    import spsp_pkg::*;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(GS_W - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [GS_W-1:0]   rem_reg, rem_next;
    logic [GS_W-1:0]   quo_reg, quo_next;
    logic [GS_W-1:0]   den_reg, den_next;
    logic [GS_W:0]     trial;

    assign trial = {rem_reg, quo_reg[GS_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = GS_W'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[GS_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[GS_W-1:0];
                quo_next = {quo_reg[GS_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

`ifndef ASSERT_OFF
    a_done_after_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !start && step_reg == LAST_STEP |=> done_reg && !busy_reg)
        else $error("divider did not finish after its last step");
`endif

endmodule

`default_nettype wire

// ===== rtl/spsp_dpath.sv =====
// Datapath: configuration registers, captured request, divider, slice plan and
// output register. Uses spsp_pkg and spsp_div; driven by spsp_ctrl commands.
`default_nettype none

module spsp_dpath #(
    parameter int MAX_PEERS = spsp_pkg::MAX_PEERS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [spsp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [spsp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic [spsp_pkg::GS_W-1:0]     group_size,
    input  wire logic [spsp_pkg::GS_W-1:0]     shard_degree,
    input  wire logic                          shard_replicated,
    input  wire logic                          out_stall,
    input  wire spsp_pkg::spsp_cmd_t           cmd,
    output spsp_pkg::spsp_stat_t               stat,
    output logic                               out_valid,
    output logic [spsp_pkg::IDX_W-1:0]         peer_index,
    output logic [spsp_pkg::GS_W-1:0]          peer_split_count,
    output logic [spsp_pkg::IDX_W-1:0]         peer_split_part,
    output logic [spsp_pkg::GS_W-1:0]          local_split_count,
    output logic [spsp_pkg::IDX_W-1:0]         local_split_part,
    output logic                               page_round_robin,
    output logic [spsp_pkg::ERR_W-1:0]         error_code,
    output logic                               last
);
    import spsp_pkg::*;

    localparam logic [GS_W-1:0] MAX_W = GS_W'(MAX_PEERS);

    // configuration
    logic [GS_W-1:0]  width_reg;
    logic [IDX_W-1:0] rank_reg;
    logic             kvrep_reg;
    logic             kvopq_reg;

    // captured request
    logic [GS_W-1:0] gs_reg;
    logic [GS_W-1:0] sd_reg;
    logic            srep_reg;

    // divider
    logic [GS_W-1:0] div_a, div_b;
    logic            div_done;
    logic [GS_W-1:0] div_q, div_r;
    logic [GS_W-1:0] g_reg;

    // slice plan
    logic [ERR_W-1:0] err_reg,   err_next;
    logic [IDX_W-1:0] base_reg,  base_next;
    logic [GS_W-1:0]  pcnt_reg,  pcnt_next;
    logic [GS_W-1:0]  lcnt_reg,  lcnt_next;
    logic [IDX_W-1:0] lpart_reg, lpart_next;
    logic             rr_reg,    rr_next;
    logic [GS_W-1:0]  lim_reg,   lim_next;
    logic             pstep_reg, pstep_next;  // peer index advances per slice
    logic             qstep_reg, qstep_next;  // peer part advances per slice
    logic [GS_W-1:0]  cnt_reg;
    logic [GS_W+IDX_W-1:0] prod;

    // output register
    logic             out_valid_reg;
    logic [IDX_W-1:0] o_peer_reg;
    logic [GS_W-1:0]  o_pcnt_reg;
    logic [IDX_W-1:0] o_ppart_reg;
    logic [GS_W-1:0]  o_lcnt_reg;
    logic [IDX_W-1:0] o_lpart_reg;
    logic             o_rr_reg;
    logic [ERR_W-1:0] o_err_reg;
    logic             o_last_reg;
    logic [IDX_W-1:0] cur_peer;
    logic [IDX_W-1:0] cur_ppart;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= GS_W'(1);
            rank_reg  <= '0;
            kvrep_reg <= 1'b0;
            kvopq_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_LOCAL_WIDTH:   width_reg <= cfg_data;
                CFG_LOCAL_RANK:    rank_reg  <= cfg_data[IDX_W-1:0];
                CFG_KV_REPLICATED: kvrep_reg <= cfg_data[0];
                CFG_KV_OPAQUE:     kvopq_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            gs_reg   <= group_size;
            sd_reg   <= shard_degree;
            srep_reg <= shard_replicated;
        end
    end

    always_comb
    begin
        unique case (cmd.div_sel)
            DIV_R_BY_GS: begin div_a = {1'b0, rank_reg}; div_b = gs_reg;    end
            DIV_GS_BY_W: begin div_a = gs_reg;           div_b = width_reg; end
            DIV_W_BY_GS: begin div_a = width_reg;        div_b = gs_reg;    end
            DIV_R_BY_G:  begin div_a = {1'b0, rank_reg}; div_b = div_q;     end
            default:     begin div_a = gs_reg;           div_b = width_reg; end
        endcase
    end

    spsp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.g_load)
            g_reg <= div_q;
    end

    assign prod = rank_reg * div_q;

    always_comb
    begin
        err_next   = ERR_OK;
        base_next  = '0;
        pcnt_next  = GS_W'(1);
        lcnt_next  = GS_W'(1);
        lpart_next = '0;
        rr_next    = 1'b0;
        lim_next   = GS_W'(1);
        pstep_next = 1'b0;
        qstep_next = 1'b0;
        unique case (cmd.plan_kind)
            PLAN_ERR:
            begin
                err_next  = cmd.err_code;
                pcnt_next = '0;
                lcnt_next = '0;
            end
            PLAN_SHARD:
            begin
                rr_next    = 1'b1;
                lim_next   = gs_reg;
                pstep_next = 1'b1;
            end
            PLAN_REP_SRC:
            begin
                base_next  = div_r[IDX_W-1:0];
                lcnt_next  = width_reg;
                lpart_next = rank_reg;
            end
            PLAN_REP_KV:
                base_next = div_r[IDX_W-1:0];
            PLAN_EQUAL:
                base_next = rank_reg;
            PLAN_FINER:
            begin
                base_next  = prod[IDX_W-1:0];
                pcnt_next  = div_q;
                lim_next   = div_q;
                pstep_next = 1'b1;
                qstep_next = 1'b1;
            end
            PLAN_COARSE:
            begin
                base_next  = div_q[IDX_W-1:0];
                lcnt_next  = g_reg;
                lpart_next = div_r[IDX_W-1:0];
            end
            default:
            begin
                err_next  = cmd.err_code;
                pcnt_next = '0;
                lcnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.plan_load)
        begin
            err_reg   <= err_next;
            base_reg  <= base_next;
            pcnt_reg  <= pcnt_next;
            lcnt_reg  <= lcnt_next;
            lpart_reg <= lpart_next;
            rr_reg    <= rr_next;
            lim_reg   <= lim_next;
            pstep_reg <= pstep_next;
            qstep_reg <= qstep_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.plan_load)
            cnt_reg <= '0;
        else if (cmd.emit)
            cnt_reg <= cnt_reg + 1'b1;
    end

    assign cur_peer  = pstep_reg ? IDX_W'(base_reg + cnt_reg[IDX_W-1:0]) : base_reg;
    assign cur_ppart = qstep_reg ? cnt_reg[IDX_W-1:0] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            o_peer_reg  <= cur_peer;
            o_pcnt_reg  <= pcnt_reg;
            o_ppart_reg <= cur_ppart;
            o_lcnt_reg  <= lcnt_reg;
            o_lpart_reg <= lpart_reg;
            o_rr_reg    <= rr_reg;
            o_err_reg   <= err_reg;
            o_last_reg  <= stat.last_item;
        end
    end

    always_comb
    begin
        stat.empty          = gs_reg == '0;
        stat.oversize       = gs_reg > MAX_W;
        stat.sharded        = sd_reg > GS_W'(1);
        stat.mismatch       = stat.sharded && gs_reg != sd_reg;
        stat.shard_mode_bad = !kvrep_reg && !kvopq_reg;
        stat.width_bad      = width_reg == '0 || width_reg > MAX_W;
        stat.rank_bad       = {1'b0, rank_reg} >= width_reg;
        stat.src_rep        = srep_reg;
        stat.kv_rep         = kvrep_reg;
        stat.equal          = gs_reg == width_reg;
        stat.finer          = gs_reg > width_reg;
        stat.div_done       = div_done;
        stat.rem_zero       = div_r == '0;
        stat.out_free       = !out_valid_reg || !out_stall;
        stat.last_item      = GS_W'(cnt_reg + 1'b1) == lim_reg;
    end

    assign out_valid         = out_valid_reg;
    assign peer_index        = o_peer_reg;
    assign peer_split_count  = o_pcnt_reg;
    assign peer_split_part   = o_ppart_reg;
    assign local_split_count = o_lcnt_reg;
    assign local_split_part  = o_lpart_reg;
    assign page_round_robin  = o_rr_reg;
    assign error_code        = o_err_reg;
    assign last              = o_last_reg;

`ifndef ASSERT_OFF
    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && o_err_reg != ERR_OK |-> o_last_reg)
        else $error("error result not marked last");

    a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.emit))
        else $error("output valid raised without an emit");
`endif

endmodule

`default_nettype wire

// ===== rtl/spsp_ctrl.sv =====
// Controller FSM: runs the checks in priority order, sequences the divider and
// steps through the slice results. Uses spsp_pkg; commands spsp_dpath.
`default_nettype none

module spsp_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire spsp_pkg::spsp_stat_t stat,
    output spsp_pkg::spsp_cmd_t       cmd
);
    import spsp_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECIDE = 3'd1;
    localparam logic [2:0] ST_DIV1   = 3'd2;
    localparam logic [2:0] ST_DIV2   = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    logic [2:0] state_reg, state_next;
    plan_kind_t kind_reg, kind_next;

    assign in_stall = state_reg != ST_IDLE;

    always_comb
    begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        cmd           = '0;
        cmd.div_sel   = DIV_R_BY_GS;
        cmd.plan_kind = PLAN_ERR;
        cmd.err_code  = ERR_OK;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = ST_EMIT;
                priority if (stat.empty)
                begin
                    cmd.plan_load = 1'b1;
                    cmd.err_code  = ERR_EMPTY;
                end
                else if (stat.oversize)
                begin
                    cmd.plan_load = 1'b1;
                    cmd.err_code  = ERR_WIDTH;
                end
                else if (stat.mismatch)
                begin
                    cmd.plan_load = 1'b1;
                    cmd.err_code  = ERR_MISMATCH;
                end
                else if (stat.sharded && stat.shard_mode_bad)
                begin
                    cmd.plan_load = 1'b1;
                    cmd.err_code  = ERR_SHARD_MODE;
                end
                else if (stat.sharded)
                begin
                    cmd.plan_load = 1'b1;
                    cmd.plan_kind = PLAN_SHARD;
                end
                else if (stat.width_bad)
                begin
                    cmd.plan_load = 1'b1;
                    cmd.err_code  = ERR_WIDTH;
                end
                else if (stat.rank_bad)
                begin
                    cmd.plan_load = 1'b1;
                    cmd.err_code  = ERR_RANK;
                end
                else if (stat.src_rep || stat.kv_rep)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_R_BY_GS;
                    kind_next     = stat.src_rep ? PLAN_REP_SRC : PLAN_REP_KV;
                    state_next    = ST_DIV1;
                end
                else if (stat.equal)
                begin
                    cmd.plan_load = 1'b1;
                    cmd.plan_kind = PLAN_EQUAL;
                end
                else if (stat.finer)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_GS_BY_W;
                    kind_next     = PLAN_FINER;
                    state_next    = ST_DIV1;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_W_BY_GS;
                    kind_next     = PLAN_COARSE;
                    state_next    = ST_DIV1;
                end
            end
            ST_DIV1:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_EMIT;
                    priority if (kind_reg == PLAN_REP_SRC || kind_reg == PLAN_REP_KV)
                    begin
                        cmd.plan_load = 1'b1;
                        cmd.plan_kind = kind_reg;
                    end
                    else if (!stat.rem_zero)
                    begin
                        cmd.plan_load = 1'b1;
                        cmd.err_code  = ERR_RATIO;
                    end
                    else if (kind_reg == PLAN_FINER)
                    begin
                        cmd.plan_load = 1'b1;
                        cmd.plan_kind = PLAN_FINER;
                    end
                    else
                    begin
                        // coarser source: rank split by the ratio just found
                        cmd.g_load    = 1'b1;
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = DIV_R_BY_G;
                        state_next    = ST_DIV2;
                    end
                end
            end
            ST_DIV2:
            begin
                if (stat.div_done)
                begin
                    cmd.plan_load = 1'b1;
                    cmd.plan_kind = PLAN_COARSE;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.last_item)
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            kind_reg  <= PLAN_ERR;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

`ifndef ASSERT_OFF
    a_plan_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.plan_load |=> state_reg == ST_EMIT)
        else $error("plan loaded but not emitting");

    a_accept_to_decide: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == ST_DECIDE && in_stall)
        else $error("accepted item did not start checks");

    a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && stat.last_item |=> !in_stall)
        else $error("input still stalled after last result");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/stage_peer_slice_planner_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for stage_peer_slice_planner: queue-fed driver, clocked monitor,
// and a slice planner of its own that predicts every result item. Depends on spsp_pkg.

module stage_peer_slice_planner_tb;
    import spsp_pkg::*;

    typedef struct {
        logic [GS_W-1:0] group_size;
        logic [GS_W-1:0] shard_degree;
        logic            shard_replicated;
    } request_t;

    typedef struct {
        logic [IDX_W-1:0] peer_index;
        logic [GS_W-1:0]  peer_split_count;
        logic [IDX_W-1:0] peer_split_part;
        logic [GS_W-1:0]  local_split_count;
        logic [IDX_W-1:0] local_split_part;
        logic             page_round_robin;
        logic [ERR_W-1:0] error_code;
        logic             last;
    } slice_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [GS_W-1:0]       group_size = '0;
    logic [GS_W-1:0]       shard_degree = '0;
    logic                  shard_replicated = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [IDX_W-1:0]      peer_index;
    logic [GS_W-1:0]       peer_split_count;
    logic [IDX_W-1:0]      peer_split_part;
    logic [GS_W-1:0]       local_split_count;
    logic [IDX_W-1:0]      local_split_part;
    logic                  page_round_robin;
    logic [ERR_W-1:0]      error_code;
    logic                  last;

    // copy of the block's registers, kept in step with every write
    logic [GS_W-1:0]  model_width = 7'd1;
    logic [IDX_W-1:0] model_rank = '0;
    logic             model_kv_rep = 1'b0;
    logic             model_opaque = 1'b0;

    request_t pending_requests[$];
    slice_t   expected_slices[$];
    request_t cur_req;
    slice_t   want;
    int       gap_left = 0;
    int       stall_left = 0;
    int       mismatch_count = 0;
    bit       idle_free = 1'b0;
    bit       send_next;
    bit       stall_next;

    stage_peer_slice_planner i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .group_size        (group_size),
        .shard_degree      (shard_degree),
        .shard_replicated  (shard_replicated),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .peer_index        (peer_index),
        .peer_split_count  (peer_split_count),
        .peer_split_part   (peer_split_part),
        .local_split_count (local_split_count),
        .local_split_part  (local_split_part),
        .page_round_robin  (page_round_robin),
        .error_code        (error_code),
        .last              (last)
    );

    always #6 clk = ~clk;

    task automatic report_mismatch(input string what, input int got, input int want_v);
        mismatch_count++;
        $display("MISMATCH @%0t: %s got %0d expected %0d", $time, what, got, want_v);
    endtask

    function automatic void push_slice(input int peer, input int pcnt, input int ppart,
                                       input int lcnt, input int lpart, input bit rr,
                                       input logic [ERR_W-1:0] err, input bit fin);
        slice_t s;
        s.peer_index        = peer[IDX_W-1:0];
        s.peer_split_count  = pcnt[GS_W-1:0];
        s.peer_split_part   = ppart[IDX_W-1:0];
        s.local_split_count = lcnt[GS_W-1:0];
        s.local_split_part  = lpart[IDX_W-1:0];
        s.page_round_robin  = rr;
        s.error_code        = err;
        s.last              = fin;
        expected_slices.insert(expected_slices.size(), s);
    endfunction

    // Work out the slice list for one accepted request under the current registers.
    function automatic void plan_slices(input request_t req);
        int gs, sd, w, r, g;
        gs = int'(req.group_size);
        sd = int'(req.shard_degree);
        w  = int'(model_width);
        r  = int'(model_rank);
        if (gs == 0)
            push_slice(0, 0, 0, 0, 0, 1'b0, ERR_EMPTY, 1'b1);
        else if (gs > MAX_PEERS_DEF)
            push_slice(0, 0, 0, 0, 0, 1'b0, ERR_WIDTH, 1'b1);
        else if (sd > 1 && gs != sd)
            push_slice(0, 0, 0, 0, 0, 1'b0, ERR_MISMATCH, 1'b1);
        else if (sd > 1) begin
            // sharded source: width and rank are not looked at
            if (!model_kv_rep && !model_opaque)
                push_slice(0, 0, 0, 0, 0, 1'b0, ERR_SHARD_MODE, 1'b1);
            else
                for (int j = 0; j < gs; j++)
                    push_slice(j, 1, 0, 1, 0, 1'b1, ERR_OK, j == gs - 1);
        end
        else if (w == 0 || w > MAX_PEERS_DEF)
            push_slice(0, 0, 0, 0, 0, 1'b0, ERR_WIDTH, 1'b1);
        else if (r >= w)
            push_slice(0, 0, 0, 0, 0, 1'b0, ERR_RANK, 1'b1);
        else if (req.shard_replicated)
            push_slice(r % gs, 1, 0, w, r, 1'b0, ERR_OK, 1'b1);
        else if (model_kv_rep)
            push_slice(r % gs, 1, 0, 1, 0, 1'b0, ERR_OK, 1'b1);
        else if (gs % w != 0 && w % gs != 0)
            push_slice(0, 0, 0, 0, 0, 1'b0, ERR_RATIO, 1'b1);
        else if (gs == w)
            push_slice(r, 1, 0, 1, 0, 1'b0, ERR_OK, 1'b1);
        else if (gs > w) begin
            g = gs / w;
            for (int j = 0; j < g; j++)
                push_slice(r * g + j, g, j, 1, 0, 1'b0, ERR_OK, j == g - 1);
        end
        else begin
            g = w / gs;
            push_slice(r / g, 1, 0, g, r % g, 1'b0, ERR_OK, 1'b1);
        end
    endfunction

    // Sender: one item per handshake, random gap after each accepted item unless idle_free is set.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left = 0;
        end
        else begin
            send_next = in_valid;
            if (in_valid && !in_stall) begin
                plan_slices(cur_req);
                send_next = 1'b0;
                gap_left = idle_free ? 0 : int'($urandom_range(0, 8));
            end
            if (!send_next) begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_requests.size() > 0) begin
                    cur_req = pending_requests.pop_front();
                    group_size       <= cur_req.group_size;
                    shard_degree     <= cur_req.shard_degree;
                    shard_replicated <= cur_req.shard_replicated;
                    send_next = 1'b1;
                end
            end
            in_valid <= send_next;
        end
    end

    // Receiver: check each accepted slice against the oldest prediction.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else begin
            if (out_valid && !out_stall) begin
                if (expected_slices.size() == 0)
                    report_mismatch("slice with nothing expected, peer_index",
                                    int'(peer_index), 0);
                else begin
                    want = expected_slices.pop_front();
                    if (peer_index !== want.peer_index)
                        report_mismatch("peer_index", int'(peer_index),
                                        int'(want.peer_index));
                    if (peer_split_count !== want.peer_split_count)
                        report_mismatch("peer_split_count", int'(peer_split_count),
                                        int'(want.peer_split_count));
                    if (peer_split_part !== want.peer_split_part)
                        report_mismatch("peer_split_part", int'(peer_split_part),
                                        int'(want.peer_split_part));
                    if (local_split_count !== want.local_split_count)
                        report_mismatch("local_split_count", int'(local_split_count),
                                        int'(want.local_split_count));
                    if (local_split_part !== want.local_split_part)
                        report_mismatch("local_split_part", int'(local_split_part),
                                        int'(want.local_split_part));
                    if (page_round_robin !== want.page_round_robin)
                        report_mismatch("page_round_robin", int'(page_round_robin),
                                        int'(want.page_round_robin));
                    if (error_code !== want.error_code)
                        report_mismatch("error_code", int'(error_code),
                                        int'(want.error_code));
                    if (last !== want.last)
                        report_mismatch("last", int'(last), int'(want.last));
                end
                stall_left = idle_free ? 0 : int'($urandom_range(0, 8));
            end
            stall_next = (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
            out_stall <= stall_next;
        end
    end

    task automatic wait_drained();
        @(negedge clk);
        while (pending_requests.size() > 0 || in_valid || expected_slices.size() > 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_LOCAL_WIDTH:   model_width  = value;
            CFG_LOCAL_RANK:    model_rank   = value[IDX_W-1:0];
            CFG_KV_REPLICATED: model_kv_rep = value[0];
            CFG_KV_OPAQUE:     model_opaque = value[0];
        endcase
    endtask

    task automatic set_config(input int w, input int r, input int kv_rep, input int opaque);
        wait_drained();
        repeat (4) @(posedge clk);
        write_reg(CFG_LOCAL_WIDTH, w[CFG_DATA_W-1:0]);
        write_reg(CFG_LOCAL_RANK, r[CFG_DATA_W-1:0]);
        write_reg(CFG_KV_REPLICATED, {6'd0, kv_rep[0]});
        write_reg(CFG_KV_OPAQUE, {6'd0, opaque[0]});
    endtask

    task automatic send(input int gs, input int sd, input int srep);
        request_t req;
        req.group_size       = gs[GS_W-1:0];
        req.shard_degree     = sd[GS_W-1:0];
        req.shard_replicated = srep[0];
        pending_requests.insert(pending_requests.size(), req);
    endtask

    // Mostly well-formed requests for the current registers, some noise.
    function automatic request_t draw_request();
        request_t req;
        int w, pick, k;
        w    = int'(model_width);
        pick = $urandom_range(0, 9);
        req.shard_replicated = 1'($urandom_range(0, 1));
        req.shard_degree     = GS_W'($urandom_range(0, 1));
        if (pick == 0) begin
            req.group_size   = GS_W'($urandom_range(0, 127));
            req.shard_degree = GS_W'($urandom_range(0, 127));
        end
        else if (pick <= 2) begin
            k = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 64) : $urandom_range(2, 8);
            req.group_size   = GS_W'(k);
            req.shard_degree = GS_W'(k);
        end
        else if (pick == 3) begin
            req.group_size   = GS_W'($urandom_range(1, 64));
            req.shard_degree = GS_W'($urandom_range(2, 127));
        end
        else if (w == 0 || w > MAX_PEERS_DEF)
            req.group_size = GS_W'($urandom_range(1, 64));
        else if (pick <= 6) begin
            // finer or equal source, mostly few slices
            k = MAX_PEERS_DEF / w;
            if (k > 4 && $urandom_range(0, 4) != 0)
                k = 4;
            req.group_size = GS_W'(w * $urandom_range(1, k));
            req.shard_replicated = ($urandom_range(0, 7) == 0);
        end
        else begin
            do
                k = $urandom_range(1, w);
            while (w % k != 0);
            req.group_size = GS_W'(k);
            req.shard_replicated = ($urandom_range(0, 7) == 0);
        end
        return req;
    endfunction

    task automatic random_phase(input int n_items);
        for (int i = 0; i < n_items; i++) begin
            // hold the sender once per phase until every slice is back
            if (i == n_items / 2)
                wait_drained();
            pending_requests.insert(pending_requests.size(), draw_request());
        end
    endtask

    initial begin
        int w, r;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset defaults: width 1, rank 0
        set_config(1, 0, 0, 0);
        send(0, 0, 0);
        send(127, 0, 0);
        send(65, 1, 1);
        send(4, 3, 0);
        send(64, 127, 0);
        send(4, 4, 0);
        send(1, 0, 0);
        send(64, 1, 0);
        send(5, 1, 1);

        set_config(64, 63, 0, 1);
        send(64, 64, 0);
        send(2, 2, 1);
        send(1, 0, 0);
        send(32, 1, 0);
        send(3, 0, 0);
        send(64, 0, 0);
        send(7, 0, 1);

        set_config(6, 5, 1, 0);
        send(4, 0, 0);
        send(12, 4, 0);
        send(3, 3, 1);

        // bad widths: sharded requests still pass
        set_config(0, 63, 1, 0);
        send(5, 0, 0);
        send(5, 5, 0);
        set_config(127, 0, 0, 0);
        send(8, 1, 1);

        // rank out of range
        set_config(8, 8, 0, 1);
        send(8, 0, 0);

        for (int p = 0; p < 8; p++) begin
            w = $urandom_range(1, 64);
            r = $urandom_range(0, w - 1);
            case (p)
                0: set_config(64, 0, 0, 0);
                1: set_config(1, 0, 0, 1);
                3: set_config(64, 63, 1, 1);
                7: set_config($urandom_range(0, 127), $urandom_range(0, 63),
                              $urandom_range(0, 1), $urandom_range(0, 1));
                default: set_config(w, r, $urandom_range(0, 1), $urandom_range(0, 1));
            endcase
            idle_free = (p == 2 || p == 5);
            random_phase(37);
        end

        wait_drained();
        idle_free = 1'b0;
        repeat (80) @(posedge clk);
        if (expected_slices.size() != 0)
            report_mismatch("slices never delivered", expected_slices.size(), 0);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
